// File: src/fpca_pkg.sv
// ----------------------------------------------------------------------------
// fpca_pkg: shared types and constants of the flag pool cell allocator
// Command and status codes, register indexes, widths and cell link types.
// ----------------------------------------------------------------------------
package fpca_pkg;

    localparam int MAX_CELLS = 64;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 13;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 2;

    // width that holds both the count register and the built maximum
    localparam int CMP_W = (COUNT_W > $clog2(MAX_CELLS + 1)) ? COUNT_W : $clog2(MAX_CELLS + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT   = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;
    localparam logic [SIZE_W-1:0]  RST_CELL_SIZE    = 13'd16;
    localparam logic [COUNT_W-1:0] RST_CELL_COUNT   = 7'd64;

    // search token handed from one cell to the next
    typedef struct packed {
        logic              tok;
        logic [ADDR_W-1:0] addr;
    } cell_link_t;

    // request fields broadcast to every cell
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] free_address;
        logic [SIZE_W-1:0] cell_size;
    } cell_ctl_t;

    // per-cell outcome
    typedef struct packed {
        logic              hit;
        logic              stop;
        logic [ADDR_W-1:0] addr;
    } cell_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   cell_address;
        logic [ADDR_W-1:0]   range_first;
        logic [ADDR_W-1:0]   range_last;
    } result_t;

endpackage

// File: src/fpca_cell.sv
// ----------------------------------------------------------------------------
// fpca_cell: one cell of the allocator chain
// Holds the occupied flag, checks the passing token and forwards it onwards.
// ----------------------------------------------------------------------------
module fpca_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpca_pkg::cell_ctl_t  ctl,
    input  logic               in_use,
    input  fpca_pkg::cell_link_t link_in,
    output fpca_pkg::cell_link_t link_out,
    output fpca_pkg::cell_stat_t stat
);
    import fpca_pkg::*;

    logic              tok_reg;
    logic              occ_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              match;

    always_comb begin
        if (ctl.cmd == CMD_ALLOC) begin
            match = ~occ_reg;
        end else begin
            match = (addr_reg == ctl.free_address);
        end
    end

    assign stat.hit  = tok_reg & in_use & match;
    assign stat.stop = tok_reg & ~in_use;
    assign stat.addr = stat.hit ? addr_reg : '0;

    assign link_out.tok  = tok_reg & in_use & ~match;
    assign link_out.addr = addr_reg + ADDR_W'(ctl.cell_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
            occ_reg <= 1'b0;
        end else begin
            tok_reg <= link_in.tok;
            if (stat.hit) begin
                occ_reg <= (ctl.cmd == CMD_ALLOC);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (link_in.tok) begin
            addr_reg <= link_in.addr;
        end
    end

endmodule

// File: src/flag_pool_cell_allocator_top.sv
// ----------------------------------------------------------------------------
// The search stops at the cell that matches, at the first cell not in use (when the pool
// is full or nothing matches) or at the end of the chain; the result is then registered.
// No word is taken while a search runs or a skid word is held; the token steps one cell a cycle.
// Reset (aresetn low, synchronous): all cells open, registers to their defaults.
// ----------------------------------------------------------------------------
// flag_pool_cell_allocator_top: fixed block pool allocator
// A token walks a chain of cells to allocate the lowest open cell or free one.
// ----------------------------------------------------------------------------
module flag_pool_cell_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fpca_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [fpca_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // free_address
    input  logic                           s_axis_tuser,  // cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [95:0]                    m_axis_tdata,  // cell_address, range_first, range_last
    output logic [1:0]                     m_axis_tuser   // status
);
    import fpca_pkg::*;

    logic [ADDR_W-1:0]  cfg_base_reg;
    logic [SIZE_W-1:0]  cfg_size_reg;
    logic [COUNT_W-1:0] cfg_count_reg;

    logic              cmd_reg;
    logic [ADDR_W-1:0] free_addr_reg;
    logic              busy_reg;

    result_t out_reg;
    logic    out_valid_reg;
    result_t hold_reg;
    logic    hold_valid_reg;

    cell_ctl_t  ctl;
    cell_link_t link [MAX_CELLS+1];
    cell_stat_t stat [MAX_CELLS];
    logic [MAX_CELLS-1:0] in_use;
    logic [MAX_CELLS-1:0] tok_vec;

    logic              s_fire;
    logic              any_hit;
    logic              any_stop;
    logic [ADDR_W-1:0] hit_addr;
    logic              done;
    logic [CMP_W-1:0]  n_used;
    logic [ADDR_W-1:0] span;
    result_t           res;

    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~busy_reg & ~hold_valid_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_reg  <= RST_BASE_ADDRESS;
            cfg_size_reg  <= RST_CELL_SIZE;
            cfg_count_reg <= RST_CELL_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_ADDRESS: cfg_base_reg  <= cfg_wdata[ADDR_W-1:0];
                REG_CELL_SIZE:    cfg_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_CELL_COUNT:   cfg_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_used = (CMP_W'(cfg_count_reg) > CMP_W'(MAX_CELLS)) ? CMP_W'(MAX_CELLS)
                                                                : CMP_W'(cfg_count_reg);

    assign ctl.cmd          = cmd_reg;
    assign ctl.free_address = free_addr_reg;
    assign ctl.cell_size    = cfg_size_reg;

    // token enters cell 0 at the accept edge
    assign link[0].tok  = s_fire;
    assign link[0].addr = cfg_base_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CELLS; gi++) begin : g_cell
            assign in_use[gi]  = CMP_W'(gi) < n_used;
            assign tok_vec[gi] = stat[gi].hit | stat[gi].stop | link[gi+1].tok;
            fpca_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .in_use   (in_use[gi]),
                .link_in  (link[gi]),
                .link_out (link[gi+1]),
                .stat     (stat[gi])
            );
        end
    endgenerate

    always_comb begin
        any_hit  = 1'b0;
        any_stop = 1'b0;
        hit_addr = '0;
        for (int i = 0; i < MAX_CELLS; i++) begin
            any_hit  = any_hit | stat[i].hit;
            any_stop = any_stop | stat[i].stop;
            hit_addr = hit_addr | stat[i].addr;
        end
    end

    // token falling off the end of the chain also finishes the search
    assign done = busy_reg & (any_hit | any_stop | link[MAX_CELLS].tok);

    assign span = ADDR_W'(n_used) * ADDR_W'(cfg_size_reg);

    always_comb begin
        res.range_first = cfg_base_reg;
        res.range_last  = cfg_base_reg + span - ADDR_W'(cfg_size_reg);
        if (cmd_reg == CMD_ALLOC) begin
            res.status       = any_hit ? ST_ALLOCATED : ST_FULL;
            res.cell_address = hit_addr;
        end else begin
            res.status       = any_hit ? ST_FREED : ST_NOT_FOUND;
            res.cell_address = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_fire) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg       <= s_axis_tuser;
            free_addr_reg <= s_axis_tdata;
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (done) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                hold_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && m_axis_tready) begin
            if (hold_valid_reg) begin
                hold_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_reg <= res;
            end else begin
                hold_reg <= res;
            end
        end else if (out_valid_reg && m_axis_tready && hold_valid_reg) begin
            out_reg <= hold_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {out_reg.range_last, out_reg.range_first, out_reg.cell_address};

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one cell holds the search token");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg)
        else $error("accepted word did not start a search");

    a_no_token_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_vec == '0))
        else $error("token in the chain while idle");

    a_hold_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for flag_pool_cell_allocator_top
// Drives allocate/free requests through the input stream, keeps its own copy
// of the occupied flags and pool registers, and checks every result word
// field by field against the predicted one, under varying stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import fpca_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_PER_POOL = 58;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;   // free_address
    logic                 s_axis_tuser = 1'b0; // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [95:0]          m_axis_tdata;        // cell_address, range_first, range_last
    logic [1:0]           m_axis_tuser;        // status

    // shadow of the pool
    logic [MAX_CELLS-1:0] cell_busy = '0;
    logic [ADDR_W-1:0]    pool_base = RST_BASE_ADDRESS;
    logic [SIZE_W-1:0]    pool_size = RST_CELL_SIZE;
    logic [COUNT_W-1:0]   pool_count = RST_CELL_COUNT;

    result_t pending_results[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_len = 0;
    int      hold_seq = 0;

    flag_pool_cell_allocator_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned cells_active();
        return (pool_count > MAX_CELLS) ? MAX_CELLS : pool_count;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned idx);
        return pool_base + 32'(idx) * 32'(pool_size);
    endfunction

    // one request against the shadow pool; updates the flags
    function automatic result_t pool_predict(input logic cmd, input logic [ADDR_W-1:0] addr);
        result_t     r;
        int unsigned n;
        logic        done;
        n = cells_active();
        done = 1'b0;
        r.status = (cmd == CMD_ALLOC) ? ST_FULL : ST_NOT_FOUND;
        r.cell_address = '0;
        r.range_first = pool_base;
        // n of zero wraps to base - size
        r.range_last = pool_base + (32'(n) - 32'd1) * 32'(pool_size);
        for (int i = 0; i < MAX_CELLS; i++) begin
            if (!done && i < n) begin
                if (cmd == CMD_ALLOC && !cell_busy[i]) begin
                    cell_busy[i] = 1'b1;
                    r.status = ST_ALLOCATED;
                    r.cell_address = cell_addr(i);
                    done = 1'b1;
                end else if (cmd == CMD_FREE && cell_addr(i) == addr) begin
                    cell_busy[i] = 1'b0;
                    r.status = ST_FREED;
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= addr;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(pool_predict(cmd, addr));
    endtask

    // allocates half the time, else mostly frees of real cell addresses, some near misses and noise
    task automatic send_random_word();
        int unsigned n;
        int unsigned pick;
        logic [ADDR_W-1:0] junk;
        n = cells_active();
        pick = $urandom_range(0, 99);
        junk = $urandom;
        if (pick < 50)
            send_word(CMD_ALLOC, junk);
        else if (pick < 85 && n != 0)
            send_word(CMD_FREE, cell_addr($urandom_range(0, n - 1)));
        else if (pick < 93)
            send_word(CMD_FREE, cell_addr($urandom_range(0, MAX_CELLS)) +
                                32'($urandom_range(0, 2)));
        else
            send_word(CMD_FREE, junk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [COUNT_W-1:0] count);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_addr  <= REG_CELL_SIZE;
        cfg_wdata <= CFG_W'(size);
        @(posedge aclk);
        cfg_addr  <= REG_CELL_COUNT;
        cfg_wdata <= CFG_W'(count);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pool_base  = base;
        pool_size  = size;
        pool_count = count;
    endtask

    task automatic test_reset_pool();
        send_word(CMD_ALLOC, 32'hFFFF_FFFF);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_FREE, 32'd16);
        send_word(CMD_FREE, 32'd16);        // already open, still freed
        send_word(CMD_FREE, 32'd8);
        send_word(CMD_FREE, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_and_lowest();
        set_pool(32'h0000_1000, 13'd4096, 7'd2);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_FREE, 32'h0000_1000);
        send_word(CMD_ALLOC, 32'h0);
    endtask

    // flags above the count survive a shrink and show again on growth
    task automatic test_beyond_count();
        set_pool(32'h0000_1000, 13'd4096, 7'd1);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_FREE, 32'h0000_2000);
        set_pool(32'h0000_1000, 13'd4096, 7'd2);
        send_word(CMD_ALLOC, 32'h0);
    endtask

    task automatic test_empty_pool();
        set_pool(32'hFFFF_FFFF, 13'd8191, 7'd0);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_FREE, 32'hFFFF_FFFF);
    endtask

    task automatic test_count_saturation();
        set_pool(32'hFFFF_FFF0, 13'd1, 7'd127);
        send_word(CMD_ALLOC, 32'h0);
    endtask

    // zero size: every cell on one address, free takes the lowest
    task automatic test_zero_size();
        set_pool(32'h0000_0040, 13'd0, 7'd3);
        send_word(CMD_ALLOC, 32'h0);
        send_word(CMD_FREE, 32'h0000_0040);
        send_word(CMD_FREE, 32'h0000_0040);
        send_word(CMD_ALLOC, 32'h0);
    endtask

    task automatic test_backpressure();
        set_pool(32'h8000_0000, 13'd32, 7'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 300;
        hold_seq++;
        repeat (10) send_random_word();
        wait_idle();
        repeat (2) send_random_word();
    endtask

    task automatic test_random(input int s_pct, input int r_pct);
        logic [ADDR_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (3) begin
            case ($urandom_range(0, 9))
                0:       count = 7'd0;
                1:       count = 7'd64;
                2:       count = 7'($urandom_range(65, 127));
                default: count = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       size = 13'd0;
                1:       size = 13'd8191;
                2:       size = 13'd4096;
                3:       size = 13'd1;
                default: size = 13'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 5))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            set_pool(base, size, count);
            repeat (RANDOM_PER_POOL) send_random_word();
        end
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_result
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d addr %h first %h last %h",
                             got.status, got.cell_address, got.range_first, got.range_last);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp status %0d addr %h first %h last %h",
                                 want.status, want.cell_address, want.range_first,
                                 want.range_last);
                        $display("          got status %0d addr %h first %h last %h",
                                 got.status, got.cell_address, got.range_first,
                                 got.range_last);
                    end
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall = 0;
            else
                stall++;
        end
        $display("FAIL flag_pool_cell_allocator_top");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        recv_idle_pct = 30;
        test_reset_pool();
        test_full_and_lowest();
        test_beyond_count();
        test_empty_pool();
        test_count_saturation();
        test_zero_size();
        test_backpressure();
        test_random(24, 64);
        test_random(64, 24);
        test_random(0, 0);
        wait_idle();
        repeat (80) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS flag_pool_cell_allocator_top");
        else
            $display("FAIL flag_pool_cell_allocator_top");
        $finish;
    end

endmodule

// File: flag_pool_cell_allocator_top.f
src/fpca_pkg.sv
src/fpca_cell.sv
src/flag_pool_cell_allocator_top.sv
sim/tb_top.sv
